### hw/rtl/tsh_pkg.sv
// ----------------------------------------------------------------------------
// Tar stream header checker package
// Shared types, field offsets and character codes for the header checker.
// ----------------------------------------------------------------------------
package tsh_pkg;

    localparam int unsigned BLOCK_BYTES = 512;
    localparam int unsigned OFF_W       = $clog2(BLOCK_BYTES);
    localparam int unsigned SIZE_W      = 64;
    localparam int unsigned BLK_LEFT_W  = SIZE_W - OFF_W;
    localparam int unsigned SUM_W       = 17;
    localparam int unsigned CK_W        = 21;
    localparam int unsigned CK_CNT_W    = 3;
    localparam int unsigned SZ_CNT_W    = 4;

    typedef logic [OFF_W-1:0] offset_t;

    // Header field positions within a 512-byte block.
    localparam offset_t SIZE_FIRST_OFF = offset_t'(124);
    localparam offset_t SIZE_LAST_OFF  = offset_t'(135);
    localparam offset_t CK_FIRST_OFF   = offset_t'(148);
    localparam offset_t CK_LAST_OFF    = offset_t'(155);
    localparam offset_t MAGIC_OFF      = offset_t'(257);
    localparam offset_t LAST_OFF       = offset_t'(BLOCK_BYTES - 1);

    // Digit limits of the octal fields, as last digit index.
    localparam logic [CK_CNT_W-1:0] CK_LAST_DIGIT = CK_CNT_W'(6);
    localparam logic [SZ_CNT_W-1:0] SZ_LAST_DIGIT = SZ_CNT_W'(10);

    // Character codes and checksum constants.
    localparam logic [7:0] CHAR_A         = 8'h61;
    localparam logic [7:0] CHAR_U         = 8'h75;
    localparam logic [7:0] CHAR_SPACE     = 8'h20;
    localparam logic [7:0] CHAR_TAB       = 8'h09;
    localparam logic [7:0] CHAR_CR        = 8'h0D;
    localparam int unsigned CK_SPACES     = 256;
    localparam int unsigned MAGIC_A_BONUS = 20;

    // Result queue between the front and the output side.
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W      = QPTR_W + 1;

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_DATA   = 2'd1,
        PH_STOP   = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        KIND_HEADER  = 2'd0,
        KIND_DATA    = 2'd1,
        KIND_IGNORED = 2'd2
    } byte_kind_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_END      = 2'd1,
        ST_MISMATCH = 2'd2
    } header_status_t;

    typedef struct packed {
        logic [7:0]        out_byte;
        byte_kind_t        byte_kind;
        logic              header_done;
        header_status_t    header_status;
        logic [SIZE_W-1:0] file_size;
    } result_t;

endpackage

### hw/rtl/tsh_front.sv
// ----------------------------------------------------------------------------
// Tar stream header checker front end
// Tracks block position and phase, parses header fields and forms one result
// for every accepted byte.
// ----------------------------------------------------------------------------
module tsh_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr,
    input  logic              cfg_bit,
    input  logic              in_fire,
    input  logic [7:0]        in_byte,
    output tsh_pkg::result_t  res
);

    function automatic logic is_space(input logic [7:0] c);
        is_space = (c == tsh_pkg::CHAR_SPACE) ||
                   ((c >= tsh_pkg::CHAR_TAB) && (c <= tsh_pkg::CHAR_CR));
    endfunction

    function automatic logic is_odigit(input logic [7:0] c);
        is_odigit = (c[7:3] == 5'b00110);
    endfunction

    logic                                decrypt_reg;
    tsh_pkg::phase_t                     phase_reg, phase_next;
    tsh_pkg::offset_t                    off_reg, off_next;
    logic [tsh_pkg::SUM_W-1:0]           sum_reg, sum_next;
    logic                                nz_reg, nz_next;
    logic [tsh_pkg::CK_W-1:0]            ck_reg, ck_next;
    logic [tsh_pkg::CK_CNT_W-1:0]        ck_cnt_reg, ck_cnt_next;
    logic                                ck_done_reg, ck_done_next;
    logic [tsh_pkg::SIZE_W-1:0]          acc_reg, acc_next;
    logic [tsh_pkg::SZ_CNT_W-1:0]        sz_cnt_reg, sz_cnt_next;
    logic                                sz_done_reg, sz_done_next;
    logic                                b256_reg, b256_next;
    logic                                magic_reg, magic_next;
    logic [tsh_pkg::BLK_LEFT_W-1:0]      blk_reg, blk_next;

    logic                                in_ck, in_sz;
    logic [tsh_pkg::SUM_W-1:0]           calc;
    logic [tsh_pkg::SIZE_W-1:0]          size_m1;

    always_comb begin
        in_ck   = (off_reg >= tsh_pkg::CK_FIRST_OFF) && (off_reg <= tsh_pkg::CK_LAST_OFF);
        in_sz   = (off_reg >= tsh_pkg::SIZE_FIRST_OFF) && (off_reg <= tsh_pkg::SIZE_LAST_OFF);
        calc    = sum_reg + tsh_pkg::SUM_W'(in_byte) + tsh_pkg::SUM_W'(tsh_pkg::CK_SPACES)
                + (magic_reg ? tsh_pkg::SUM_W'(tsh_pkg::MAGIC_A_BONUS) : '0);
        size_m1 = acc_reg - tsh_pkg::SIZE_W'(1);

        phase_next   = phase_reg;
        off_next     = off_reg;
        sum_next     = sum_reg;
        nz_next      = nz_reg;
        ck_next      = ck_reg;
        ck_cnt_next  = ck_cnt_reg;
        ck_done_next = ck_done_reg;
        acc_next     = acc_reg;
        sz_cnt_next  = sz_cnt_reg;
        sz_done_next = sz_done_reg;
        b256_next    = b256_reg;
        magic_next   = magic_reg;
        blk_next     = blk_reg;

        res.out_byte      = in_byte;
        res.byte_kind     = tsh_pkg::KIND_HEADER;
        res.header_done   = 1'b0;
        res.header_status = tsh_pkg::ST_OK;
        res.file_size     = '0;

        unique case (phase_reg)
            tsh_pkg::PH_HEADER: begin
                off_next = off_reg + tsh_pkg::offset_t'(1);
                nz_next  = nz_reg | (in_byte != 8'h00);
                // The checksum field's own bytes are kept out of the sum.
                if (!in_ck) begin
                    sum_next = sum_reg + tsh_pkg::SUM_W'(in_byte);
                end
                if (in_ck && !ck_done_reg) begin
                    if (is_odigit(in_byte)) begin
                        ck_next     = {ck_reg[tsh_pkg::CK_W-4:0], in_byte[2:0]};
                        ck_cnt_next = ck_cnt_reg + tsh_pkg::CK_CNT_W'(1);
                        if (ck_cnt_reg == tsh_pkg::CK_LAST_DIGIT) begin
                            ck_done_next = 1'b1;
                        end
                    end else if (!((ck_cnt_reg == '0) && is_space(in_byte))) begin
                        ck_done_next = 1'b1;
                    end
                end
                if (in_sz) begin
                    if ((off_reg == tsh_pkg::SIZE_FIRST_OFF) && in_byte[7]) begin
                        b256_next = 1'b1;
                    end else if (b256_reg) begin
                        acc_next = {acc_reg[tsh_pkg::SIZE_W-9:0], in_byte};
                    end else if (!sz_done_reg) begin
                        if (is_odigit(in_byte)) begin
                            acc_next    = {acc_reg[tsh_pkg::SIZE_W-4:0], in_byte[2:0]};
                            sz_cnt_next = sz_cnt_reg + tsh_pkg::SZ_CNT_W'(1);
                            if (sz_cnt_reg == tsh_pkg::SZ_LAST_DIGIT) begin
                                sz_done_next = 1'b1;
                            end
                        end else if (!((sz_cnt_reg == '0) && is_space(in_byte))) begin
                            sz_done_next = 1'b1;
                        end
                    end
                end
                if (off_reg == tsh_pkg::MAGIC_OFF) begin
                    magic_next   = (in_byte == tsh_pkg::CHAR_A);
                    res.out_byte = decrypt_reg ? tsh_pkg::CHAR_U : tsh_pkg::CHAR_A;
                end
                if (off_reg == tsh_pkg::LAST_OFF) begin
                    res.header_done = 1'b1;
                    if (!nz_next) begin
                        res.header_status = tsh_pkg::ST_END;
                        phase_next        = tsh_pkg::PH_STOP;
                    end else if ({{(tsh_pkg::CK_W - tsh_pkg::SUM_W){1'b0}}, calc} != ck_reg) begin
                        res.header_status = tsh_pkg::ST_MISMATCH;
                        phase_next        = tsh_pkg::PH_STOP;
                    end else begin
                        res.file_size = acc_reg;
                        if (acc_reg != '0) begin
                            blk_next   = size_m1[tsh_pkg::SIZE_W-1:tsh_pkg::OFF_W];
                            phase_next = tsh_pkg::PH_DATA;
                        end
                    end
                    sum_next     = '0;
                    nz_next      = 1'b0;
                    ck_next      = '0;
                    ck_cnt_next  = '0;
                    ck_done_next = 1'b0;
                    acc_next     = '0;
                    sz_cnt_next  = '0;
                    sz_done_next = 1'b0;
                    b256_next    = 1'b0;
                    magic_next   = 1'b0;
                end
            end
            tsh_pkg::PH_DATA: begin
                res.byte_kind = tsh_pkg::KIND_DATA;
                off_next      = off_reg + tsh_pkg::offset_t'(1);
                if (off_reg == tsh_pkg::LAST_OFF) begin
                    if (blk_reg == '0) begin
                        phase_next = tsh_pkg::PH_HEADER;
                    end else begin
                        blk_next = blk_reg - tsh_pkg::BLK_LEFT_W'(1);
                    end
                end
            end
            tsh_pkg::PH_STOP: begin
                res.byte_kind = tsh_pkg::KIND_IGNORED;
            end
            default: begin
                res.byte_kind = tsh_pkg::KIND_IGNORED;
                phase_next    = tsh_pkg::PH_STOP;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            decrypt_reg <= 1'b0;
        end else if (cfg_wr) begin
            decrypt_reg <= cfg_bit;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= tsh_pkg::PH_HEADER;
            off_reg     <= '0;
            sum_reg     <= '0;
            nz_reg      <= 1'b0;
            ck_reg      <= '0;
            ck_cnt_reg  <= '0;
            ck_done_reg <= 1'b0;
            acc_reg     <= '0;
            sz_cnt_reg  <= '0;
            sz_done_reg <= 1'b0;
            b256_reg    <= 1'b0;
            magic_reg   <= 1'b0;
            blk_reg     <= '0;
        end else if (in_fire) begin
            phase_reg   <= phase_next;
            off_reg     <= off_next;
            sum_reg     <= sum_next;
            nz_reg      <= nz_next;
            ck_reg      <= ck_next;
            ck_cnt_reg  <= ck_cnt_next;
            ck_done_reg <= ck_done_next;
            acc_reg     <= acc_next;
            sz_cnt_reg  <= sz_cnt_next;
            sz_done_reg <= sz_done_next;
            b256_reg    <= b256_next;
            magic_reg   <= magic_next;
            blk_reg     <= blk_next;
        end
    end

endmodule

### hw/rtl/tsh_queue.sv
// ----------------------------------------------------------------------------
// Tar stream header checker result queue
// Small first-in first-out store that parts the front end from the output.
// ----------------------------------------------------------------------------
module tsh_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  tsh_pkg::result_t  push_data,
    output logic              full,
    input  logic              pop,
    output logic              pop_valid,
    output tsh_pkg::result_t  pop_data
);

    tsh_pkg::result_t                 slot_reg [tsh_pkg::QUEUE_DEPTH];
    logic [tsh_pkg::QPTR_W-1:0]       wr_ptr_reg, rd_ptr_reg;
    logic [tsh_pkg::QCNT_W-1:0]       count_reg, count_next;
    logic                             do_pop;

    assign full      = (count_reg == tsh_pkg::QCNT_W'(tsh_pkg::QUEUE_DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_data  = slot_reg[rd_ptr_reg];
    assign do_pop    = pop && pop_valid;

    always_comb begin
        count_next = count_reg;
        if (push && !do_pop) begin
            count_next = count_reg + tsh_pkg::QCNT_W'(1);
        end else if (!push && do_pop) begin
            count_next = count_reg - tsh_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + tsh_pkg::QPTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + tsh_pkg::QPTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

endmodule

### hw/rtl/tar_stream_header_checker.sv
// ----------------------------------------------------------------------------
// Tar stream header checker
// Walks a tar archive byte stream, checks header checksums, parses member
// sizes and tags each byte as header, file data or ignored.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake             Payload
// s_        in         s_tvalid / s_tready   s_tdata: archive byte
// m_        out        m_tvalid / m_tready   m_tdata, m_tuser, m_tlast
// cfg_      in         cfg_valid / cfg_ready cfg_data: decrypt mode bit
//
// Every accepted byte yields exactly one result, and a new byte can be taken
// on every clock cycle while the queue has room. The front end updates all
// header parsing state in the cycle the byte is accepted, so one byte per
// cycle follows from that update. Results wait in a four-entry queue, so the
// input keeps flowing while the output is stalled until the queue is full,
// after which s_tready drops. Reset is synchronous and active low; it empties
// the queue and returns the walker to the first byte of a header block, with no
// clearing pass needed. The configuration request is always accepted at once.
//
module tar_stream_header_checker (
    input  logic        aclk,
    input  logic        aresetn,

    // Input stream. s_tdata: [7:0] in_byte.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,

    // Result stream. m_tdata: [7:0] out_byte, [9:8] header_status,
    // [73:10] file_size, [79:74] zero. m_tuser: [1:0] byte_kind.
    // m_tlast: header_done.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,
    output logic [1:0]  m_tuser,
    output logic        m_tlast,

    // Configuration write. cfg_data: [0] decrypt_mode.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_data
);

    tsh_pkg::result_t front_res;
    tsh_pkg::result_t out_res;
    logic             queue_full;
    logic             s_fire;

    // The front end sees a byte only when the queue has room for its result.
    assign s_tready  = !queue_full;
    assign s_fire    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    tsh_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg_wr  (cfg_valid && cfg_ready),
        .cfg_bit (cfg_data[0]),
        .in_fire (s_fire),
        .in_byte (s_tdata),
        .res     (front_res)
    );

    tsh_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (s_fire),
        .push_data (front_res),
        .full      (queue_full),
        .pop       (m_tready),
        .pop_valid (m_tvalid),
        .pop_data  (out_res)
    );

    // Pack the result fields onto the stream ports, lowest field first.
    assign m_tdata = {6'b000000, out_res.file_size, out_res.header_status, out_res.out_byte};
    assign m_tuser = out_res.byte_kind;
    assign m_tlast = out_res.header_done;

    // A non-zero size is only ever reported with a good header.
    a_size_only_on_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tdata[73:10] != '0)) |->
        (m_tlast && (m_tdata[9:8] == tsh_pkg::ST_OK)))
        else $error("file size reported outside a good header");

    // A byte taken while the queue is empty must show up on the output next.
    a_fire_reaches_output: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && !m_tvalid) |=> m_tvalid)
        else $error("accepted byte did not reach the output");

    // No result appears without a byte having been accepted.
    a_no_invented_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_tvalid && !s_fire) |=> !m_tvalid)
        else $error("result appeared without an accepted byte");

endmodule

### tb/testbench.sv
// ----------------------------------------------------------------------------
// Tar stream header checker testbench
// Streams a short tar archive through the header checker: a sound member
// header with an octal or base-256 size, its data block, and a closing end
// block or bad header followed by trailing bytes. Every result is compared
// field by field with a byte-accurate predictor of the header walker, under
// random stalls on both sides and one long output hold-off.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned STALL_LIMIT = 5000;
    localparam int unsigned HOLD_CYCLES = 400;
    localparam int unsigned TAIL_CYCLES = 8;
    localparam int unsigned TAIL_BYTES  = 264;
    localparam int          SIZE_LEN    = int'(tsh_pkg::SIZE_LAST_OFF)
                                        - int'(tsh_pkg::SIZE_FIRST_OFF) + 1;
    localparam int          CK_LEN      = int'(tsh_pkg::CK_LAST_OFF)
                                        - int'(tsh_pkg::CK_FIRST_OFF) + 1;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_SEVEN = 8'h37;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;

    // How a generated header spoils its checksum field, if at all.
    typedef enum {CKF_GOOD, CKF_WRONG, CKF_SIGNED, CKF_EMPTY} ck_fault_t;
    typedef enum {SZF_OCTAL, SZF_BASE256} size_form_t;
    typedef enum {FILL_RANDOM, FILL_SPARSE, FILL_FULL} fill_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [79:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [0:0]  cfg_data  = '0;

    tar_stream_header_checker dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #4 aclk = ~aclk;

    // Predictor state, starting from the reset values of the walker.
    tsh_pkg::offset_t                walk_off     = '0;
    tsh_pkg::phase_t                 walk_phase   = tsh_pkg::PH_HEADER;
    logic [tsh_pkg::SUM_W-1:0]       hdr_sum      = '0;
    logic [10:0]                     ck_field_sum = '0;
    logic [tsh_pkg::CK_W-1:0]        ck_value     = '0;
    int unsigned                     ck_digits    = 0;
    bit                              ck_done      = 1'b0;
    logic [tsh_pkg::SIZE_W-1:0]      size_acc     = '0;
    int unsigned                     size_digits  = 0;
    bit                              size_done    = 1'b0;
    bit                              size_b256    = 1'b0;
    bit                              magic_a      = 1'b0;
    logic [tsh_pkg::BLK_LEFT_W-1:0]  blocks_left  = '0;
    logic                            decrypt_mode = 1'b0;

    tsh_pkg::result_t predicted_q [$];
    logic [7:0]       blk [tsh_pkg::BLOCK_BYTES];
    int unsigned      error_count     = 0;
    int unsigned      bytes_sent      = 0;
    int unsigned      members_sent    = 0;
    int unsigned      results_checked = 0;
    int unsigned      src_idle_pct    = 0;
    int unsigned      snk_idle_pct    = 0;
    int unsigned      hold_left       = 0;
    int unsigned      stall_cycles    = 0;
    bit               hold_request    = 1'b0;
    string            stop_desc       = "nothing";

    function automatic bit is_blank(input logic [7:0] c);
        return c == tsh_pkg::CHAR_SPACE ||
               (c >= tsh_pkg::CHAR_TAB && c <= tsh_pkg::CHAR_CR);
    endfunction

    function automatic bit is_octal(input logic [7:0] c);
        return c >= CHAR_ZERO && c <= CHAR_SEVEN;
    endfunction

    function automatic int octal_width(input longint unsigned v);
        int n;
        n = 0;
        while (v != 0) begin
            n++;
            v = v >> 3;
        end
        return n;
    endfunction

    // Advances the predicted walker by one archive byte and returns the
    // result the block should emit for it.
    function automatic tsh_pkg::result_t walk_archive_byte(input logic [7:0] b);
        tsh_pkg::result_t r;
        int unsigned      calc;
        r.out_byte      = b;
        r.byte_kind     = tsh_pkg::KIND_HEADER;
        r.header_done   = 1'b0;
        r.header_status = tsh_pkg::ST_OK;
        r.file_size     = '0;
        case (walk_phase)
            tsh_pkg::PH_STOP: begin
                r.byte_kind = tsh_pkg::KIND_IGNORED;
            end
            tsh_pkg::PH_DATA: begin
                r.byte_kind = tsh_pkg::KIND_DATA;
                if (walk_off == tsh_pkg::LAST_OFF) begin
                    if (blocks_left == 0)
                        walk_phase = tsh_pkg::PH_HEADER;
                    else
                        blocks_left = blocks_left - 1'b1;
                end
                walk_off = walk_off + 1'b1;
            end
            default: begin
                hdr_sum = hdr_sum + b;
                if (walk_off >= tsh_pkg::CK_FIRST_OFF && walk_off <= tsh_pkg::CK_LAST_OFF) begin
                    ck_field_sum = ck_field_sum + b;
                    if (!ck_done) begin
                        if (is_octal(b)) begin
                            ck_value = {ck_value[tsh_pkg::CK_W-4:0], b[2:0]};
                            ck_digits++;
                            if (ck_digits == 7)
                                ck_done = 1'b1;
                        end else if (!(ck_digits == 0 && is_blank(b))) begin
                            ck_done = 1'b1;
                        end
                    end
                end
                if (walk_off >= tsh_pkg::SIZE_FIRST_OFF &&
                    walk_off <= tsh_pkg::SIZE_LAST_OFF) begin
                    if (walk_off == tsh_pkg::SIZE_FIRST_OFF && b[7]) begin
                        size_b256 = 1'b1;
                    end else if (size_b256) begin
                        size_acc = {size_acc[tsh_pkg::SIZE_W-9:0], b};
                    end else if (!size_done) begin
                        if (is_octal(b)) begin
                            size_acc = {size_acc[tsh_pkg::SIZE_W-4:0], b[2:0]};
                            size_digits++;
                            if (size_digits == 11)
                                size_done = 1'b1;
                        end else if (!(size_digits == 0 && is_blank(b))) begin
                            size_done = 1'b1;
                        end
                    end
                end
                if (walk_off == tsh_pkg::MAGIC_OFF) begin
                    magic_a    = (b == tsh_pkg::CHAR_A);
                    r.out_byte = decrypt_mode ? tsh_pkg::CHAR_U : tsh_pkg::CHAR_A;
                end
                if (walk_off == tsh_pkg::LAST_OFF) begin
                    r.header_done = 1'b1;
                    if (hdr_sum == 0) begin
                        r.header_status = tsh_pkg::ST_END;
                        walk_phase      = tsh_pkg::PH_STOP;
                    end else begin
                        calc = hdr_sum - ck_field_sum + tsh_pkg::CK_SPACES
                               + (magic_a ? tsh_pkg::MAGIC_A_BONUS : 0);
                        if (calc != ck_value) begin
                            r.header_status = tsh_pkg::ST_MISMATCH;
                            walk_phase      = tsh_pkg::PH_STOP;
                        end else begin
                            r.file_size = size_acc;
                            if (size_acc != 0) begin
                                blocks_left = tsh_pkg::BLK_LEFT_W'((size_acc - 1) >> 9);
                                walk_phase  = tsh_pkg::PH_DATA;
                            end
                        end
                    end
                    hdr_sum      = '0;
                    ck_field_sum = '0;
                    ck_value     = '0;
                    ck_digits    = 0;
                    ck_done      = 1'b0;
                    size_acc     = '0;
                    size_digits  = 0;
                    size_done    = 1'b0;
                    size_b256    = 1'b0;
                    magic_a      = 1'b0;
                end
                walk_off = walk_off + 1'b1;
            end
        endcase
        return r;
    endfunction

    // Offers one archive byte, after a random gap, and records the predicted
    // result once the request has been taken.
    task automatic send_byte(input logic [7:0] b);
        while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        predicted_q.push_back(walk_archive_byte(b));
        bytes_sent++;
    endtask

    task automatic send_block();
        for (int i = 0; i < tsh_pkg::BLOCK_BYTES; i++)
            send_byte(blk[i]);
    endtask

    // Stops offering bytes and waits until every predicted result has come out.
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (predicted_q.size() != 0);
    endtask

    task automatic write_decrypt_mode(input logic mode);
        wait_for_results();
        cfg_valid <= 1'b1;
        cfg_data  <= mode;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid    <= 1'b0;
        decrypt_mode  = mode;
    endtask

    // Writes an octal text field: optional leading white space, leading
    // zeros, the digits, a terminator where the field leaves room, and junk.
    task automatic put_octal_field(input int first, input int len, input int max_digits,
                                   input longint unsigned value);
        int         digits, lead, pos, j;
        logic [7:0] t;
        digits = $urandom_range(max_digits, octal_width(value));
        lead   = (digits == len) ? 0 : $urandom_range(len - digits, 0);
        for (j = 0; j < lead; j++) begin
            t = 8'($urandom_range(13, 8));
            blk[first + j] = (t == 8'd8) ? tsh_pkg::CHAR_SPACE : t;
        end
        for (j = 0; j < digits; j++)
            blk[first + lead + j] = CHAR_ZERO + 8'((value >> (3 * (digits - 1 - j))) & 7);
        pos = first + lead + digits;
        if (pos < first + len && (digits == 0 || digits < max_digits)) begin
            if (digits != 0 && $urandom_range(1) == 1) begin
                blk[pos] = tsh_pkg::CHAR_SPACE;
            end else begin
                do t = 8'($urandom_range(255)); while (is_octal(t) || is_blank(t));
                blk[pos] = t;
            end
            pos++;
        end
        for (j = pos; j < first + len; j++)
            blk[j] = 8'($urandom_range(255));
    endtask

    task automatic make_header(input logic [63:0] size, input size_form_t form,
                               input logic [7:0] magic, input ck_fault_t fault,
                               input fill_t fill);
        int unsigned target;
        for (int i = 0; i < tsh_pkg::BLOCK_BYTES; i++) begin
            case (fill)
                FILL_FULL:   blk[i] = 8'hFF;
                FILL_SPARSE: blk[i] = ($urandom_range(7) == 0) ?
                                      8'($urandom_range(126, 32)) : 8'h00;
                default:     blk[i] = 8'($urandom_range(255));
            endcase
        end
        blk[0] = 8'($urandom_range(255, 1));
        if (form == SZF_OCTAL) begin
            put_octal_field(int'(tsh_pkg::SIZE_FIRST_OFF), SIZE_LEN, 11, size);
        end else begin
            // The three top digit bytes fall off the 64-bit result.
            blk[tsh_pkg::SIZE_FIRST_OFF] = 8'h80 | 8'($urandom_range(127));
            for (int i = 1; i < 4; i++)
                blk[int'(tsh_pkg::SIZE_FIRST_OFF) + i] = 8'($urandom_range(255));
            for (int i = 0; i < 8; i++)
                blk[int'(tsh_pkg::SIZE_FIRST_OFF) + 4 + i] = size[63 - 8 * i -: 8];
        end
        blk[tsh_pkg::MAGIC_OFF] = magic;
        target = tsh_pkg::CK_SPACES + ((magic == tsh_pkg::CHAR_A) ? tsh_pkg::MAGIC_A_BONUS : 0);
        for (int i = 0; i < tsh_pkg::BLOCK_BYTES; i++)
            if (i < int'(tsh_pkg::CK_FIRST_OFF) || i > int'(tsh_pkg::CK_LAST_OFF))
                target += blk[i];
        case (fault)
            CKF_GOOD:  put_octal_field(int'(tsh_pkg::CK_FIRST_OFF), CK_LEN, 7, target);
            CKF_WRONG: put_octal_field(int'(tsh_pkg::CK_FIRST_OFF), CK_LEN, 7,
                                       target ^ (1 << $urandom_range(2, 0)));
            CKF_SIGNED: begin
                put_octal_field(int'(tsh_pkg::CK_FIRST_OFF) + 1, CK_LEN - 1, 7, target);
                blk[tsh_pkg::CK_FIRST_OFF] = ($urandom_range(1) == 1) ? CHAR_PLUS : CHAR_MINUS;
            end
            default:   put_octal_field(int'(tsh_pkg::CK_FIRST_OFF), CK_LEN, 0, 0);
        endcase
    endtask

    // One file data block, mostly random with scattered zero bytes.
    task automatic send_data_block();
        for (int i = 0; i < tsh_pkg::BLOCK_BYTES; i++)
            blk[i] = ($urandom_range(7) == 0) ? 8'h00 : 8'($urandom_range(255));
        send_block();
    endtask

    // A sound member header whose size calls for exactly one data block, in
    // the octal or the base-256 form, with the magic 'a' bonus.
    task automatic test_good_header();
        logic [63:0] size;
        size_form_t  form;
        fill_t       fill;
        size = 64'($urandom_range(512, 1));
        form = ($urandom_range(1) == 0) ? SZF_BASE256 : SZF_OCTAL;
        fill = fill_t'($urandom_range(2));
        make_header(size, form, tsh_pkg::CHAR_A, CKF_GOOD, fill);
        send_block();
        members_sent++;
    endtask

    // The receiver stops for a long stretch while the data block is being
    // offered, so the result queue fills and the input request is held off.
    task automatic test_output_backpressure();
        hold_request = 1'b1;
        send_data_block();
    endtask

    // Closes the archive with an end block or a bad checksum, then checks
    // that everything behind it is passed through as ignored.
    task automatic test_archive_stop();
        int unsigned pick;
        pick = $urandom_range(3);
        if (pick == 0) begin
            stop_desc = "an all-zero end block";
            for (int i = 0; i < tsh_pkg::BLOCK_BYTES; i++)
                blk[i] = 8'h00;
        end else begin
            stop_desc = (pick == 1) ? "a wrong checksum digit" :
                        (pick == 2) ? "a signed checksum" : "a checksum without digits";
            make_header(64'd0, SZF_OCTAL, tsh_pkg::CHAR_A, ck_fault_t'(pick), FILL_RANDOM);
        end
        send_block();
        members_sent++;
        for (int i = 0; i < TAIL_BYTES; i++)
            send_byte(8'($urandom_range(255)));
    endtask

    // Receiver: checks each result taken against the oldest prediction and
    // drives the ready, including the long hold-off when one is requested.
    initial begin
        tsh_pkg::result_t exp;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                if (predicted_q.size() == 0) begin
                    error_count++;
                    $display("%0t: unexpected result, expected none, got tdata %h tuser %h",
                             $time, m_tdata, m_tuser);
                end else begin
                    exp = predicted_q.pop_front();
                    results_checked++;
                    if (m_tdata[7:0] !== exp.out_byte) begin
                        error_count++;
                        $display("%0t: out_byte expected %h, actual %h",
                                 $time, exp.out_byte, m_tdata[7:0]);
                    end
                    if (m_tuser !== exp.byte_kind) begin
                        error_count++;
                        $display("%0t: byte_kind expected %0d, actual %0d",
                                 $time, exp.byte_kind, m_tuser);
                    end
                    if (m_tlast !== exp.header_done) begin
                        error_count++;
                        $display("%0t: header_done expected %b, actual %b",
                                 $time, exp.header_done, m_tlast);
                    end
                    if (m_tdata[9:8] !== exp.header_status) begin
                        error_count++;
                        $display("%0t: header_status expected %0d, actual %0d",
                                 $time, exp.header_status, m_tdata[9:8]);
                    end
                    if (m_tdata[73:10] !== exp.file_size) begin
                        error_count++;
                        $display("%0t: file_size expected %0d, actual %0d",
                                 $time, exp.file_size, m_tdata[73:10]);
                    end
                end
            end
            if (hold_request && hold_left == 0)
                hold_left = HOLD_CYCLES;
            if (hold_left != 0) begin
                hold_left--;
                m_tready <= 1'b0;
                if (hold_left == 0)
                    hold_request = 1'b0;
            end else begin
                m_tready <= (snk_idle_pct == 0) || ($urandom_range(99) >= snk_idle_pct);
            end
        end
    end

    // Watchdog: a run in which no request is taken for too long has hung.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("%0t: no request taken for %0d cycles", $time, stall_cycles);
                $display("tar_stream_header_checker test failed");
                $finish;
            end
        end
    end

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Sender gaps light, receiver stalls heavy.
        src_idle_pct = 20;
        snk_idle_pct = 60;
        write_decrypt_mode(1'b0);
        test_good_header();

        // The other way round, with the long output hold-off.
        src_idle_pct = 60;
        snk_idle_pct = 20;
        write_decrypt_mode(1'b1);
        test_output_backpressure();

        // Full rate on both sides while the archive is closed.
        src_idle_pct = 0;
        snk_idle_pct = 0;
        test_archive_stop();

        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge aclk);
        $display("Streamed %0d headers in %0d bytes, %0d results checked, under three stall mixes.",
                 members_sent, bytes_sent, results_checked);
        $display("Both magic rewrite modes were used and the archive ended on %s.", stop_desc);
        if (error_count == 0) begin
            $display("tar_stream_header_checker test passed");
        end else begin
            $display("tar_stream_header_checker test failed");
        end
        $finish;
    end

endmodule
